// File: src/assert_macros.svh
// assertion helpers used by the core rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock outside reset
`define ITW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define ITW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/itw_pkg.sv
package itw_pkg;

  localparam int WHEEL_DEPTH_DEF = 16;
  localparam int MAX_CONNS_DEF   = 16;

  localparam int CFG_W = 5;
  localparam int ID_W  = 4;
  localparam int ID_SPAN = 1 << ID_W;

  localparam logic [CFG_W-1:0] IDLE_TICKS_RST = 5'd10;

  localparam logic [1:0] FN_TICK       = 2'd0;
  localparam logic [1:0] FN_CONNECT    = 2'd1;
  localparam logic [1:0] FN_MESSAGE    = 2'd2;
  localparam logic [1:0] FN_DISCONNECT = 2'd3;

  // broadcast to every slot cell
  typedef struct packed {
    logic tick;
    logic connect;
    logic message;
    logic disconnect;
    logic clear;
    logic shift;
  } itw_ctl_t;

endpackage

// File: src/itw_cell.sv
module itw_cell
  import itw_pkg::*;
#(
  parameter int WHEEL_DEPTH = WHEEL_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  itw_ctl_t                       ctl,
  input  logic                           sel,
  input  logic [$clog2(WHEEL_DEPTH)-1:0] ob_idx,
  input  logic [$clog2(WHEEL_DEPTH)-1:0] nb_idx,
  input  logic                           pend_in,
  output logic                           pend_out
);

  localparam int CNW = $clog2(WHEEL_DEPTH + 1);

  // one bit per bucket: this slot's entry sits in that bucket
  logic [WHEEL_DEPTH-1:0] mem_r, mem_nxt;
  logic [CNW-1:0]         cnt_r, cnt_nxt;
  logic                   conn_r, conn_nxt;
  logic                   pend_r, pend_nxt;

  always_comb begin
    mem_nxt  = mem_r;
    cnt_nxt  = cnt_r;
    conn_nxt = conn_r;
    pend_nxt = pend_r;
    if (ctl.clear) begin
      mem_nxt = '0;
      cnt_nxt = '0;
    end else if (ctl.tick) begin
      mem_nxt[ob_idx] = 1'b0;
      pend_nxt = 1'b0;
      if (mem_r[ob_idx] && (cnt_r != '0)) begin
        cnt_nxt  = cnt_r - CNW'(1);
        pend_nxt = (cnt_r == CNW'(1)) && conn_r;
      end
    end else if (ctl.shift) begin
      pend_nxt = pend_in;
    end else if (sel && ctl.connect) begin
      if (cnt_r == '0) begin
        mem_nxt[nb_idx] = 1'b1;
        cnt_nxt  = CNW'(1);
        conn_nxt = 1'b1;
      end
    end else if (sel && ctl.message) begin
      if ((cnt_r != '0) && !mem_r[nb_idx]) begin
        mem_nxt[nb_idx] = 1'b1;
        cnt_nxt = cnt_r + CNW'(1);
      end
    end else if (sel && ctl.disconnect) begin
      conn_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_r  <= '0;
      cnt_r  <= '0;
      conn_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      mem_r  <= mem_nxt;
      cnt_r  <= cnt_nxt;
      conn_r <= conn_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign pend_out = pend_r;

endmodule

// File: src/idle_timeout_timing_wheel_core.sv
// idle connection timeout timing wheel
// input channel (in_valid/in_stall) takes events: tick, connect, message,
// disconnect, each naming a connection slot in in_conn_id (ignored for tick).
// connect, message and disconnect give no result.
// a tick ages the oldest bucket in every slot cell at once, then a pending
// chain shifts one slot per cycle toward cell 0; each expired, still
// connected slot gives a result with out_shutdown_req set, in ascending
// slot order, and a final marker with out_last set closes the tick.
// after a tick in_stall stays high through the walk, including any output
// stall, until the marker is issued; only then is the next event taken.
// each result is registered: the tick sets the pending flags and starts the
// walk, and the walk then loads the output registers slot by slot.
// a stalled output holds its result and freezes the walk on the next
// shutdown; slots with nothing to report still advance.
// cfg_we writes idle_ticks (0 acts as 1, above WHEEL_DEPTH clamps) and
// empties the wheel without results; connected flags stay.
// reset empties the wheel, clears the connected and pending flags, and sets idle_ticks to 10.
`include "assert_macros.svh"

module idle_timeout_timing_wheel_core
  import itw_pkg::*;
#(
  parameter int WHEEL_DEPTH = WHEEL_DEPTH_DEF,
  parameter int MAX_CONNS   = MAX_CONNS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_func,
  input  logic [ID_W-1:0]  in_conn_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [ID_W-1:0]  out_slot_id,
  output logic             out_shutdown_req,
  output logic             out_last
);

  localparam int BW = $clog2(WHEEL_DEPTH);
  localparam int NW = $clog2(WHEEL_DEPTH + 1);
  localparam int XW = (NW > CFG_W) ? NW : CFG_W;
  localparam int SW = $clog2(MAX_CONNS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  function automatic logic [NW-1:0] wheel_size(input logic [CFG_W-1:0] v);
    logic [XW-1:0] ve;
    ve = XW'(v);
    if (v == '0) begin
      return NW'(1);
    end else if (ve > XW'(WHEEL_DEPTH)) begin
      return NW'(WHEEL_DEPTH);
    end else begin
      return NW'(ve);
    end
  endfunction

  logic              state_r, state_nxt;
  logic [SW-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic [NW-1:0]     wsize_r, wsize_nxt;
  logic [BW-1:0]     oldest_r, oldest_nxt;
  logic [BW-1:0]     newest;
  logic [BW-1:0]     oldest_inc;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_slot_r, out_slot_nxt;
  logic              out_req_r, out_req_nxt;
  logic              out_last_r, out_last_nxt;
  logic              acc;
  logic              out_free;
  logic              head_pend;
  itw_ctl_t          ctl;
  logic [MAX_CONNS-1:0] sel;
  logic [MAX_CONNS:0]   pend_chain;

  assign in_stall = (state_r == ST_SCAN);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign head_pend = pend_chain[0];

  assign newest     = (oldest_r == '0) ? BW'(wsize_r - NW'(1)) : oldest_r - BW'(1);
  assign oldest_inc = ((NW'(oldest_r) + NW'(1)) == wsize_r) ? '0 : oldest_r + BW'(1);

  always_comb begin
    ctl            = '0;
    ctl.tick       = acc && (in_func == FN_TICK);
    ctl.connect    = acc && (in_func == FN_CONNECT);
    ctl.message    = acc && (in_func == FN_MESSAGE);
    ctl.disconnect = acc && (in_func == FN_DISCONNECT);
    ctl.clear      = cfg_we;
    state_nxt      = state_r;
    scan_cnt_nxt   = scan_cnt_r;
    wsize_nxt      = cfg_we ? wheel_size(cfg_wdata) : wsize_r;
    oldest_nxt     = oldest_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_slot_nxt   = out_slot_r;
    out_req_nxt    = out_req_r;
    out_last_nxt   = out_last_r;
    if (cfg_we) begin
      oldest_nxt = '0;
    end else if (ctl.tick) begin
      oldest_nxt = oldest_inc;
    end
    case (state_r)
      ST_IDLE: begin
        if (ctl.tick) begin
          state_nxt    = ST_SCAN;
          scan_cnt_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_r == SW'(MAX_CONNS)) begin
          // tick-end marker
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_slot_nxt  = '0;
            out_req_nxt   = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (!head_pend || out_free) begin
          ctl.shift    = 1'b1;
          scan_cnt_nxt = scan_cnt_r + SW'(1);
          if (head_pend) begin
            out_valid_nxt = 1'b1;
            out_slot_nxt  = ID_W'(scan_cnt_r);
            out_req_nxt   = 1'b1;
            out_last_nxt  = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      wsize_r     <= wheel_size(IDLE_TICKS_RST);
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      wsize_r     <= wsize_nxt;
      oldest_r    <= oldest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_slot_r <= out_slot_nxt;
    out_req_r  <= out_req_nxt;
    out_last_r <= out_last_nxt;
  end

  assign pend_chain[MAX_CONNS] = 1'b0;

  for (genvar s = 0; s < MAX_CONNS; s++) begin : g_cell
    if (s < ID_SPAN) begin : g_sel
      assign sel[s] = (in_conn_id == ID_W'(s));
    end else begin : g_nosel
      assign sel[s] = 1'b0;
    end

    itw_cell #(
      .WHEEL_DEPTH(WHEEL_DEPTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .sel      (sel[s]),
      .ob_idx   (oldest_r),
      .nb_idx   (newest),
      .pend_in  (pend_chain[s+1]),
      .pend_out (pend_chain[s])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_slot_id      = out_slot_r;
  assign out_shutdown_req = out_req_r;
  assign out_last         = out_last_r;

  `ITW_ASSERT_IMP(a_one_kind, out_valid_r, out_req_r != out_last_r, "result is neither shutdown nor marker")
  `ITW_ASSERT_IMP(a_marker_zero, out_valid_r && out_last_r, out_slot_r == '0, "marker carries a slot")
  `ITW_ASSERT_NXT(a_tick_scans, ctl.tick, state_r == ST_SCAN, "tick did not start the walk")
  `ITW_ASSERT_IMP(a_scan_bound, state_r == ST_SCAN, scan_cnt_r <= SW'(MAX_CONNS), "walk ran past last slot")
  `ITW_ASSERT(a_oldest_range, NW'(oldest_r) < wsize_r, "oldest bucket outside wheel")

endmodule
